// ===== rtl/core/smw_pkg.sv =====
// shared constants and types of the sliding window median filter
// no dependencies; used by every module in rtl/core
`default_nettype none

package smw_pkg;

   // defaults for the top level parameters
   localparam int MAX_WINDOW_DEFAULT  = 64;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // window size register
   localparam int CSR_BITS = 7;
   localparam logic [CSR_BITS-1:0] WINDOW_RESET = 7'd3;

   // control broadcast to every cell of the sorted row
   typedef struct packed {
      logic load;   // a sample transfer happens this cycle
      logic full;   // the window is full, so the oldest sample leaves
   } smw_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/smw_cell.sv =====
// one cell of the sorted row: holds one sample and its age
// depends on smw_pkg
`default_nettype none

module smw_cell #(
   parameter int SAMPLE_BITS = smw_pkg::SAMPLE_BITS_DEFAULT,
   parameter int AGE_BITS    = 6
) (
   input  wire logic                   clock,
   input  wire smw_pkg::smw_ctrl_type  ctrl,
   input  wire logic                   cell_valid,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   input  wire logic [SAMPLE_BITS-1:0] evict_val,
   input  wire logic [AGE_BITS-1:0]    age_last,
   input  wire logic [SAMPLE_BITS-1:0] left_val,
   input  wire logic [AGE_BITS-1:0]    left_age,
   input  wire logic                   left_move_right,
   input  wire logic [SAMPLE_BITS-1:0] right_val,
   input  wire logic [AGE_BITS-1:0]    right_age,
   input  wire logic                   right_move_left,
   output      logic [SAMPLE_BITS-1:0] val,
   output      logic [AGE_BITS-1:0]    age,
   output      logic                   evict,
   output      logic                   move_left,
   output      logic                   move_right
);

   logic [SAMPLE_BITS-1:0] val_ff, val_in;
   logic [AGE_BITS-1:0]    age_ff, age_in;
   logic                   keep;
   logic                   after_evict;
   logic                   above_new;
   logic                   stay;

   assign keep        = cell_valid && !evict;
   assign evict       = ctrl.full && cell_valid && (age_ff == age_last);
   // ties sort by age, so an equal survivor always sits after the evicted one
   assign after_evict = ctrl.full && keep && (val_ff >= evict_val);
   // new sample goes after all equal values
   assign above_new   = keep && (val_ff > sample);
   assign move_left   = after_evict && !above_new;
   assign move_right  = above_new && !after_evict;
   assign stay        = keep && (after_evict == above_new);

   always_comb begin
      val_in = val_ff;
      age_in = age_ff;
      if (ctrl.load) begin
         if (left_move_right) begin
            val_in = left_val;
            age_in = left_age + AGE_BITS'(1);
         end else if (right_move_left) begin
            val_in = right_val;
            age_in = right_age + AGE_BITS'(1);
         end else if (stay) begin
            age_in = age_ff + AGE_BITS'(1);
         end else begin
            // insertion slot (or a slot past the end of the window)
            val_in = sample;
            age_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      age_ff <= age_in;
   end

   assign val = val_ff;
   assign age = age_ff;

endmodule

`default_nettype wire

// ===== rtl/core/smw_out_queue.sv =====
// two-entry result queue that parts the sorted row from the result channel
// depends on smw_pkg
`default_nettype none

module smw_out_queue #(
   parameter int SAMPLE_BITS = smw_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic [SAMPLE_BITS-1:0] push_data,
   output      logic [1:0]             count,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [SAMPLE_BITS-1:0] rsp_median
);

   logic [1:0]             count_ff, count_in;
   logic [SAMPLE_BITS-1:0] slot0_ff, slot0_in;
   logic [SAMPLE_BITS-1:0] slot1_ff, slot1_in;
   logic                   pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
         if (count_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end else if (pop && push) begin
         if (count_ff == 2'd1) begin
            slot0_in = push_data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign count      = count_ff;
   assign rsp_median = slot0_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_median.sv =====
// top level of the sliding window lower-median filter
// depends on smw_pkg, smw_cell and smw_out_queue
//
// Takes unsigned samples and, once the last window_size samples are held,
// returns their lower median (rank ceil(w/2), the smaller middle value for
// even windows); nothing is returned while the window fills. The samples
// live in a row of MAX_WINDOW cells kept in ascending order; on each
// transfer every cell compares itself with the new sample and the evicted
// oldest sample and moves one place left, right or stays, so insert and
// evict finish together and the filter sustains one sample per clock while
// the result queue has room. The row registers the sorted window, then the
// middle cell is picked into a two-entry result queue. A sample with
// end_of_stream set is processed and then the window is emptied; a write
// to window_size also empties it. Size 0 acts as 1, sizes above MAX_WINDOW
// as MAX_WINDOW. Write window_size only while the filter is idle.
`default_nettype none

module sliding_window_median #(
   parameter int MAX_WINDOW  = smw_pkg::MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = smw_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // sample channel
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [SAMPLE_BITS-1:0]       req_sample,
   input  wire logic                         req_end_of_stream,
   // result channel
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [SAMPLE_BITS-1:0]       rsp_median,
   // window size register
   input  wire logic                         csr_write_enable,
   input  wire logic [smw_pkg::CSR_BITS-1:0] csr_write_data
);

   // age of a sample runs 0 .. w-1
   localparam int AGE_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   // fill count and window size run 0 .. MAX_WINDOW
   localparam int FILL_BITS = $clog2(MAX_WINDOW + 1);

   logic [smw_pkg::CSR_BITS-1:0] window_ff;
   logic [FILL_BITS-1:0]         fill_ff, fill_in;
   logic                         pending_ff, pending_in;

   logic [FILL_BITS-1:0]   win_eff;
   logic [AGE_BITS-1:0]    age_last;
   logic [AGE_BITS-1:0]    rank_idx;
   logic [FILL_BITS-1:0]   fill_next;
   logic                   full;
   logic                   accept;
   logic                   pop;
   logic [2:0]             backlog;
   logic [1:0]             queue_count;
   logic [SAMPLE_BITS-1:0] evict_val;
   smw_pkg::smw_ctrl_type  ctrl;

   logic [SAMPLE_BITS-1:0] cell_val   [MAX_WINDOW];
   logic [AGE_BITS-1:0]    cell_age   [MAX_WINDOW];
   logic                   cell_evict [MAX_WINDOW];
   logic                   cell_left  [MAX_WINDOW];
   logic                   cell_right [MAX_WINDOW];

   // effective window size: zero acts as one, saturate at the row length
   always_comb begin
      if (window_ff == '0) begin
         win_eff = FILL_BITS'(1);
      end else if (32'(window_ff) > MAX_WINDOW) begin
         win_eff = FILL_BITS'(MAX_WINDOW);
      end else begin
         win_eff = FILL_BITS'(window_ff);
      end
   end

   assign age_last = AGE_BITS'(win_eff - FILL_BITS'(1));
   // lower median rank ceil(w/2), as a zero based cell index
   assign rank_idx = AGE_BITS'(((FILL_BITS + 1)'(win_eff) + 1'b1) >> 1) - AGE_BITS'(1);
   assign full     = (fill_ff == win_eff);

   // ready while the queue plus the result in flight leave room, or while a result leaves
   assign pop       = rsp_valid && rsp_ready;
   assign backlog   = 3'(queue_count) + 3'(pending_ff);
   assign req_ready = (backlog < 3'd2) || pop;
   assign accept    = req_valid && req_ready;

   assign ctrl.load = accept;
   assign ctrl.full = full;

   // value of the cell that holds the oldest sample (one-hot select)
   always_comb begin
      evict_val = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (cell_evict[i]) begin
            evict_val = evict_val | cell_val[i];
         end
      end
   end

   // sorted cell row
   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] left_val,  right_val;
      logic [AGE_BITS-1:0]    left_age,  right_age;
      logic                   left_move, right_move;
      logic                   valid_here;

      assign valid_here = (32'(fill_ff) > i);

      if (i == 0) begin : g_first
         assign left_val  = cell_val[i];
         assign left_age  = cell_age[i];
         assign left_move = 1'b0;
      end else begin : g_inner_left
         assign left_val  = cell_val[i-1];
         assign left_age  = cell_age[i-1];
         assign left_move = cell_right[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_last
         assign right_val  = cell_val[i];
         assign right_age  = cell_age[i];
         assign right_move = 1'b0;
      end else begin : g_inner_right
         assign right_val  = cell_val[i+1];
         assign right_age  = cell_age[i+1];
         assign right_move = cell_left[i+1];
      end

      smw_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_BITS    (AGE_BITS)
      ) u_cell (
         .clock           (clock),
         .ctrl            (ctrl),
         .cell_valid      (valid_here),
         .sample          (req_sample),
         .evict_val       (evict_val),
         .age_last        (age_last),
         .left_val        (left_val),
         .left_age        (left_age),
         .left_move_right (left_move),
         .right_val       (right_val),
         .right_age       (right_age),
         .right_move_left (right_move),
         .val             (cell_val[i]),
         .age             (cell_age[i]),
         .evict           (cell_evict[i]),
         .move_left       (cell_left[i]),
         .move_right      (cell_right[i])
      );
   end

   // fill count and result flag
   assign fill_next = full ? fill_ff : (fill_ff + FILL_BITS'(1));

   always_comb begin
      fill_in    = fill_ff;
      pending_in = 1'b0;
      if (csr_write_enable) begin
         fill_in = '0;
      end else if (accept) begin
         // full window after this sample means a median is due
         pending_in = (fill_next == win_eff);
         fill_in    = req_end_of_stream ? '0 : fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= smw_pkg::WINDOW_RESET;
         fill_ff    <= '0;
         pending_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_ff <= csr_write_data;
         end
         fill_ff    <= fill_in;
         pending_ff <= pending_in;
      end
   end

   // the row holds the sorted window in the cycle after the transfer
   smw_out_queue #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (pending_ff),
      .push_data  (cell_val[rank_idx]),
      .count      (queue_count),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_median (rsp_median)
   );

endmodule

`default_nettype wire

// ===== bench/sliding_window_median_tb.sv =====
// self-checking testbench for the sliding window lower-median filter
// depends on smw_pkg and sliding_window_median; a queue-fed driver and a monitor
// check every median against a window tracker kept inside the bench
`default_nettype none

module sliding_window_median_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS    = smw_pkg::SAMPLE_BITS_DEFAULT;
   localparam int MAX_WINDOW     = smw_pkg::MAX_WINDOW_DEFAULT;
   localparam int CSR_BITS       = smw_pkg::CSR_BITS;
   // settle time after the last median, so the filter is idle
   localparam int SETTLE_CYCLES  = 8;
   // a correct run goes quiet only for stall bursts and settle pauses
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 14;
   localparam int PHASE_ITEMS    = 100;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   eos;
   } sample_item_type;

   // every block input starts from a known value
   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_BITS-1:0] req_sample        = '0;
   logic                   req_end_of_stream = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready         = 1'b0;
   logic [SAMPLE_BITS-1:0] rsp_median;
   logic                   csr_write_enable  = 1'b0;
   logic [CSR_BITS-1:0]    csr_write_data    = '0;

   // stimulus waiting for the driver
   sample_item_type pending [$];
   sample_item_type next_item;

   // window tracker: the held samples in arrival order, oldest at the front
   logic [CSR_BITS-1:0]    window_size = smw_pkg::WINDOW_RESET;
   logic [SAMPLE_BITS-1:0] window_line [$];
   logic [SAMPLE_BITS-1:0] median_expected [$];
   logic [SAMPLE_BITS-1:0] median_due;

   int  failures    = 0;
   int  send_gap    = 0;
   int  recv_gap    = 0;
   int  idle_cycles = 0;
   // no random idle bursts on either side in the closing stretch
   logic steady = 1'b0;

   sliding_window_median dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_median        (rsp_median),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // size zero behaves as one, anything past the row length saturates
   function automatic int effective_size(input logic [CSR_BITS-1:0] size);
      if (size == 0) return 1;
      if (size > MAX_WINDOW) return MAX_WINDOW;
      return size;
   endfunction

   // full-range values half the time, with extremes and a narrow band for duplicates
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2, 3, 4: begin
            return SAMPLE_BITS'($urandom_range(0, 7));
         end
         default: begin
            return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
         end
      endcase
   endfunction

   task automatic note_failure(input string what);
      failures++;
      if (failures <= 10) begin
         $display("%s", what);
      end
   endtask

   // one accepted sample: shift it in, evict the oldest once full, and when
   // the window is full rank the held samples to pick the lower median
   task automatic track_sample(input logic [SAMPLE_BITS-1:0] sample, input logic eos);
      logic [SAMPLE_BITS-1:0] ranked [MAX_WINDOW];
      logic [SAMPLE_BITS-1:0] key;
      int w;
      int j;
      w = effective_size(window_size);
      if (window_line.size() == w) begin
         key = window_line.pop_front();
      end
      window_line = {window_line, sample};
      if (window_line.size() == w) begin
         // insertion sort of the held samples, ascending
         for (int i = 0; i < w; i++) begin
            key = window_line[i];
            j = i;
            while (j > 0 && ranked[j-1] > key) begin
               ranked[j] = ranked[j-1];
               j--;
            end
            ranked[j] = key;
         end
         // rank ceil(w/2), so an even window gives the smaller middle value
         median_expected = {median_expected, ranked[(w + 1) / 2 - 1]};
      end
      // end of stream is processed normally, then the window is emptied
      if (eos) begin
         window_line.delete();
      end
   endtask

   task automatic queue_sample(input logic [SAMPLE_BITS-1:0] sample, input logic eos);
      sample_item_type item;
      item.sample = sample;
      item.eos    = eos;
      pending = {pending, item};
   endtask

   // wait until every sample is taken and every median has come back, then
   // let the pipeline settle so the filter is idle
   task automatic wait_drained();
      @(negedge clock);
      while (pending.size() != 0 || req_valid || median_expected.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // a register write also empties the window
   task automatic write_window(input logic [CSR_BITS-1:0] size);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= size;
      window_size = size;
      window_line.delete();
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // one random phase at a given size: mostly whole streams no shorter than
   // the window, some cut short before it fills, most closed by end of stream
   task automatic run_phase(input logic [CSR_BITS-1:0] size, input int count);
      int w;
      int len;
      int queued;
      w = effective_size(size);
      wait_drained();
      write_window(size);
      queued = 0;
      while (queued < count) begin
         if (w > 1 && $urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, w - 1);
         end else begin
            len = w + $urandom_range(0, 2 * w + 8);
         end
         for (int i = 0; i < len; i++) begin
            queue_sample(pick_sample(), (i == len - 1) && ($urandom_range(0, 3) != 0));
         end
         queued += len;
      end
   endtask

   // driver: presents the next pending item, holds it until its transfer,
   // and now and then inserts a random idle burst
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            track_sample(req_sample, req_end_of_stream);
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending.size() != 0 && !steady && $urandom_range(0, 7) == 0) begin
               send_gap  <= $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               next_item = pending.pop_front();
               req_valid         <= 1'b1;
               req_sample        <= next_item.sample;
               req_end_of_stream <= next_item.eos;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each median transfer against the oldest expectation and
   // stalls the result channel in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (median_expected.size() == 0) begin
               note_failure($sformatf("unexpected median %0d with none pending", rsp_median));
            end else begin
               median_due = median_expected.pop_front();
               if (rsp_median !== median_due) begin
                  note_failure($sformatf("median mismatch: expected %0d, got %0d",
                                         median_due, rsp_median));
               end
            end
         end
         if (recv_gap != 0) begin
            recv_gap  <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 6) == 0) begin
            recv_gap  <= $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, at the reset size of three: extremes and duplicates
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'h0000, 1'b0);
      // end of stream on a full window still gives its median
      queue_sample(16'h8000, 1'b1);
      // stream shorter than the window: no median, window emptied
      queue_sample(16'd7, 1'b1);
      // partial fill, then a register write must empty the window
      queue_sample(16'd9, 1'b0);
      queue_sample(16'd9, 1'b0);
      wait_drained();
      write_window(7'd3);
      queue_sample(16'd5, 1'b0);
      queue_sample(16'd6, 1'b0);
      queue_sample(16'd4, 1'b1);
      // even window gives the smaller middle value
      wait_drained();
      write_window(7'd2);
      queue_sample(16'd10, 1'b0);
      queue_sample(16'd20, 1'b0);
      queue_sample(16'd20, 1'b0);
      queue_sample(16'd5, 1'b1);
      // size zero acts as a window of one
      wait_drained();
      write_window(7'd0);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'h0001, 1'b1);

      // random phases: extremes of the size first, then mostly small sizes
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               run_phase(7'd64, PHASE_ITEMS);
            end
            1: begin
               run_phase(7'd127, PHASE_ITEMS);
            end
            2: begin
               run_phase(7'd0, PHASE_ITEMS);
            end
            3: begin
               run_phase(7'd1, PHASE_ITEMS);
            end
            4: begin
               run_phase(7'd65, PHASE_ITEMS);
            end
            RANDOM_PHASES - 1: begin
               // closing stretch runs at full rate on both sides
               wait_drained();
               steady = 1'b1;
               run_phase(CSR_BITS'($urandom_range(2, 8)), PHASE_ITEMS);
            end
            default: begin
               if (p % 3 == 0) begin
                  run_phase(CSR_BITS'($urandom_range(0, 127)), PHASE_ITEMS);
               end else begin
                  run_phase(CSR_BITS'($urandom_range(1, 10)), PHASE_ITEMS);
               end
            end
         endcase
      end

      wait_drained();
      if (median_expected.size() != 0) begin
         note_failure("medians still outstanding at the end");
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/smw_pkg.sv
rtl/core/smw_cell.sv
rtl/core/smw_out_queue.sv
rtl/core/sliding_window_median.sv
bench/sliding_window_median_tb.sv
